### rtl/feedback_bus_sensor_shifter_assert.svh
// ----------------------------------------------------------------------------
// Feedback bus sensor shifter assertion macros
// Clocked assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FEEDBACK_BUS_SENSOR_SHIFTER_ASSERT_SVH
`define FEEDBACK_BUS_SENSOR_SHIFTER_ASSERT_SVH

`ifndef SYNTH
// Check on every clock edge outside reset.
`define FBSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check on every clock edge, reset included.
`define FBSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBSS_ASSERT(lbl, prop, msg)
`define FBSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/fbss_pkg.sv
// ----------------------------------------------------------------------------
// Feedback bus sensor shifter package
// Request codes, register map, widths and the command passed to the core.
// ----------------------------------------------------------------------------
package fbss_pkg;

    localparam int BLOCK_BITS = 16;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 8;
    localparam int CFG_W      = 3;
    localparam int REQ_W      = 2;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLOCK  = 2'd2;

    // Register index, taken from paddr[2]
    localparam logic REG_BLOCK_COUNT = 1'b0;

    localparam logic [CFG_W-1:0]      BLOCK_COUNT_RST = 3'd1;
    localparam logic [BLOCK_BITS-1:0] WORD_RST        = 16'hFFFF;
    localparam logic [COUNT_W-1:0]    MAGIC_COUNT     = 8'd20;
    localparam logic [COUNT_W-1:0]    COUNT_MAX       = 8'd255;

    typedef struct packed {
        logic             adv;
        logic [REQ_W-1:0] req_type;
        logic             chain_in;
    } core_cmd_t;

endpackage

### rtl/feedback_bus_sensor_shifter.sv
// ----------------------------------------------------------------------------
// Feedback bus sensor shifter
// Slave on a daisy-chained feedback shift bus with up to four sensor blocks.
//
//   channel   direction  handshake           payload
//   request   in         in_valid/in_stall   req_type, sensor_levels, chain_in
//   result    out        out_valid/out_stall data_out
//   config    in         APB write/read      block_count at byte 0
//
// One request per clock while in_stall is low; each request passes through the input
// register and then the result register around the core before its result is
// valid on the output.
// Every request gives exactly one result carrying the output level as updated by it.
// A stalled result holds while the input register keeps accepting until full.
// Reset is immediate: no clearing pass, all state is in flip-flops.
// ----------------------------------------------------------------------------
`include "feedback_bus_sensor_shifter_assert.svh"

module feedback_bus_sensor_shifter
    import fbss_pkg::*;
#(
    parameter int MAX_BLOCKS = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [PADDR_W-1:0]               paddr,
    input  logic [PDATA_W-1:0]               pwdata,
    output logic [PDATA_W-1:0]               prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [REQ_W-1:0]                 req_type,
    input  logic [MAX_BLOCKS*BLOCK_BITS-1:0] sensor_levels,
    input  logic                             chain_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             data_out
);

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic [REQ_W-1:0]                 s1_req_reg;
    logic                             s1_chain_reg;
    logic [MAX_BLOCKS*BLOCK_BITS-1:0] s1_levels_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic                             data_out_reg;

    logic             out_free;
    logic             adv;
    logic             accept;
    logic             level_next;
    logic [CFG_W-1:0] block_count;
    core_cmd_t        cmd;

    fbss_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .block_count (block_count)
    );

    assign out_free = !out_valid_reg || !out_stall;
    assign adv      = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !adv);
    assign out_valid_next = adv || (out_valid_reg && out_stall);

    assign cmd.adv      = adv;
    assign cmd.req_type = s1_req_reg;
    assign cmd.chain_in = s1_chain_reg;

    fbss_core #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sensor_levels (s1_levels_reg),
        .block_count   (block_count),
        .level_next    (level_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg    <= req_type;
            s1_chain_reg  <= chain_in;
            s1_levels_reg <= sensor_levels;
        end
        if (adv)
        begin
            data_out_reg <= level_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;

    `FBSS_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid_reg, "stall with empty input register")
    `FBSS_ASSERT(a_adv_gives_result, adv |=> out_valid_reg, "advanced item produced no result")
    `FBSS_ASSERT(a_result_drains, (out_valid_reg && !out_stall && !adv) |=> !out_valid_reg, "result repeated")

endmodule

### rtl/fbss_regs.sv
// ----------------------------------------------------------------------------
// Feedback bus sensor shifter configuration registers
// APB-style register port holding the active block count.
// ----------------------------------------------------------------------------
module fbss_regs
    import fbss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [CFG_W-1:0]   block_count
);

    logic [CFG_W-1:0] block_count_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BLOCK_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg <= BLOCK_COUNT_RST;
        end
        else if (wr_en)
        begin
            block_count_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_BLOCK_COUNT)
        begin
            prdata = {{(PDATA_W-CFG_W){1'b0}}, block_count_reg};
        end
    end

    assign block_count = block_count_reg;

endmodule

### rtl/fbss_core.sv
// ----------------------------------------------------------------------------
// Feedback bus sensor shifter core
// Sensor latches, shift words, bit position, load count and output level.
// ----------------------------------------------------------------------------
`include "feedback_bus_sensor_shifter_assert.svh"

module fbss_core
    import fbss_pkg::*;
#(
    parameter int MAX_BLOCKS = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  core_cmd_t                        cmd,
    input  logic [MAX_BLOCKS*BLOCK_BITS-1:0] sensor_levels,
    input  logic [CFG_W-1:0]                 block_count,
    output logic                             level_next
);

    localparam logic [CFG_W-1:0] MAX_N = CFG_W'(MAX_BLOCKS);

    logic [BLOCK_BITS-1:0] latch_reg [MAX_BLOCKS];
    logic [BLOCK_BITS-1:0] latch_next[MAX_BLOCKS];
    logic [BLOCK_BITS-1:0] word_reg  [MAX_BLOCKS];
    logic [BLOCK_BITS-1:0] word_next [MAX_BLOCKS];
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;
    logic                  level_reg;

    logic [CFG_W-1:0]      n_act;
    logic [CFG_W-1:0]      last_idx;
    logic [MAX_BLOCKS-1:0] active;
    logic [MAX_BLOCKS-1:0] is_last;
    logic [MAX_BLOCKS-1:0] feed_bit;
    logic                  magic;

    // Clamp the block count into 1..MAX_BLOCKS
    always_comb
    begin
        if (block_count == '0)
            n_act = CFG_W'(1);
        else if (block_count > MAX_N)
            n_act = MAX_N;
        else
            n_act = block_count;
    end

    assign last_idx = n_act - CFG_W'(1);
    assign magic    = (count_reg == MAGIC_COUNT);

    for (genvar gb = 0; gb < MAX_BLOCKS; gb++)
    begin : g_blk
        assign active[gb]  = (CFG_W'(gb) < n_act);
        assign is_last[gb] = (CFG_W'(gb) == last_idx);
        // Bit that moves down from the next block at the current position; chain_in for the last block
        if (gb < MAX_BLOCKS - 1)
        begin : g_up
            assign feed_bit[gb] = is_last[gb] ? cmd.chain_in : word_reg[gb+1][pos_reg];
        end
        else
        begin : g_end
            assign feed_bit[gb] = cmd.chain_in;
        end
    end

    always_comb
    begin
        latch_next = latch_reg;
        word_next  = word_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        level_next = level_reg;
        case (cmd.req_type)
            REQ_SAMPLE:
            begin
                for (int b = 0; b < MAX_BLOCKS; b++)
                begin
                    if (active[b])
                    begin
                        latch_next[b] = latch_reg[b]
                                      | ~sensor_levels[b*BLOCK_BITS +: BLOCK_BITS]
                                      | {{(BLOCK_BITS-1){1'b0}},
                                         magic && ((b == 0) || is_last[b])};
                    end
                end
            end
            REQ_LOAD:
            begin
                pos_next = '0;
                for (int b = 0; b < MAX_BLOCKS; b++)
                begin
                    if (active[b])
                    begin
                        word_next[b]  = latch_reg[b];
                        latch_next[b] = '0;
                    end
                end
                if (count_reg != COUNT_MAX)
                    count_next = count_reg + COUNT_W'(1);
            end
            REQ_CLOCK:
            begin
                level_next = word_reg[0][pos_reg];
                for (int b = 0; b < MAX_BLOCKS; b++)
                begin
                    if (active[b])
                        word_next[b][pos_reg] = feed_bit[b];
                end
                pos_next = pos_reg + POS_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < MAX_BLOCKS; b++)
            begin
                latch_reg[b] <= '0;
                word_reg[b]  <= WORD_RST;
            end
            pos_reg   <= '0;
            count_reg <= '0;
            level_reg <= 1'b0;
        end
        else if (cmd.adv)
        begin
            latch_reg <= latch_next;
            word_reg  <= word_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

    `FBSS_ASSERT(a_count_monotonic, count_reg >= $past(count_reg), "load count went down")
    `FBSS_ASSERT(a_load_pos, (cmd.adv && cmd.req_type == REQ_LOAD) |=> (pos_reg == '0), "load did not zero position")
    `FBSS_ASSERT(a_clock_pos, (cmd.adv && cmd.req_type == REQ_CLOCK) |=> (pos_reg == POS_W'($past(pos_reg) + POS_W'(1))), "clock did not step position")
    `FBSS_ASSERT(a_level_hold, (cmd.adv && cmd.req_type != REQ_CLOCK) |=> (level_reg == $past(level_reg)), "level changed without clock")

endmodule
